// ----- src/spicd_pkg.sv -----
// Package for the serial clock divider search block.
// Holds the controller state type, the command/status structs and fixed constants.
// No dependencies.
`default_nettype none

package spicd_pkg;

  localparam logic [31:0] CLK_RESET_HZ = 32'd125000000;
  localparam logic [7:0]  PRESCALE_MIN = 8'd2;
  localparam logic [7:0]  PRESCALE_MAX = 8'd254;
  localparam logic [8:0]  POSTDIV_MAX  = 9'd256;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE,
    ST_MUL,
    ST_POST_INIT,
    ST_POST,
    ST_DIV_INIT,
    ST_DIV,
    ST_DONE,
    ST_FAIL
  } state_t;

  typedef struct packed {
    logic load;
    logic pre_step;
    logic mul;
    logic post_init;
    logic post_step;
    logic div_init;
    logic div_step;
    logic out_load;
    logic out_err;
  } dp_cmd_t;

  typedef struct packed {
    logic pre_hit;
    logic pre_last;
    logic post_hit;
    logic post_two;
    logic div_last;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- src/spicd_ctrl.sv -----
// Controller for the serial clock divider search.
// Sequences prescaler search, post-divider search and division; owns handshakes.
// Depends on spicd_pkg.
`default_nettype none

module spicd_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire                 out_ready,
  output spicd_pkg::dp_cmd_t  cmd,
  input  spicd_pkg::dp_sts_t  sts
);
  import spicd_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (in_valid) state_nxt = ST_PRE;
      ST_PRE: begin
        if (sts.pre_hit)       state_nxt = ST_MUL;
        else if (sts.pre_last) state_nxt = ST_FAIL;
      end
      ST_MUL:       state_nxt = ST_POST_INIT;
      ST_POST_INIT: state_nxt = ST_POST;
      ST_POST:      if (sts.post_hit || sts.post_two) state_nxt = ST_DIV_INIT;
      ST_DIV_INIT:  state_nxt = ST_DIV;
      ST_DIV:       if (sts.div_last) state_nxt = ST_DONE;
      ST_DONE:      if (out_free) state_nxt = ST_IDLE;
      ST_FAIL:      if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE:      cmd.load = in_valid;
      ST_PRE:       cmd.pre_step = !sts.pre_hit;
      ST_MUL:       cmd.mul = 1'b1;
      ST_POST_INIT: cmd.post_init = 1'b1;
      // with no hit at post-divider 2 one more step leaves it at 1
      ST_POST:      cmd.post_step = !sts.post_hit;
      ST_DIV_INIT:  cmd.div_init = 1'b1;
      ST_DIV:       cmd.div_step = 1'b1;
      ST_DONE:      cmd.out_load = out_free;
      ST_FAIL: begin
        cmd.out_load = out_free;
        cmd.out_err  = 1'b1;
      end
      default:      cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

endmodule

`default_nettype wire

// ----- src/spicd_dp.sv -----
// Datapath for the serial clock divider search: clock register, search
// accumulators, restoring divider and result registers.
// Depends on spicd_pkg.
`default_nettype none

module spicd_dp (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_we,
  input  wire  [31:0]         cfg_input_clock_hz,
  input  wire  [31:0]         in_requested_rate,
  input  spicd_pkg::dp_cmd_t  cmd,
  output spicd_pkg::dp_sts_t  sts,
  output logic [7:0]          out_prescale_value,
  output logic [7:0]          out_rate_field,
  output logic [30:0]         out_achieved_rate,
  output logic                out_too_low
);
  import spicd_pkg::*;

  logic [31:0] clk_hz_r;
  logic [31:0] rate_r;
  logic [7:0]  pre_r;
  logic [47:0] acc_r;   // (pre + 2) * 256 * rate
  logic [39:0] pr_r;    // pre * (rate + 1)
  logic [47:0] prod_r;  // pre * (post - 1) * (rate + 1)
  logic [15:0] d_r;     // pre * (post - 1)
  logic [8:0]  post_r;
  logic [15:0] den_r;
  logic [15:0] rem_r;
  logic [31:0] quo_r;
  logic [4:0]  cnt_r;

  logic [32:0] rate_p1;
  logic [39:0] pr_mul;
  logic [16:0] trial;
  logic        fits;
  logic [7:0]  rate_field;

  assign rate_p1    = {1'b0, rate_r} + 33'd1;
  assign pr_mul     = {32'd0, pre_r} * {7'd0, rate_p1};
  assign trial      = {rem_r, quo_r[31]};
  assign fits       = trial >= {1'b0, den_r};
  assign rate_field = 8'(post_r - 9'd1);

  // floor(clk / d) > rate  is  clk >= d * (rate + 1)
  assign sts.pre_hit  = {16'd0, clk_hz_r} < acc_r;
  assign sts.pre_last = (pre_r == PRESCALE_MAX);
  assign sts.post_hit = {16'd0, clk_hz_r} >= prod_r;
  assign sts.post_two = (post_r == 9'd2);
  assign sts.div_last = (cnt_r == 5'd31);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= CLK_RESET_HZ;
    end else if (cfg_we) begin
      clk_hz_r <= cfg_input_clock_hz;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rate_r <= in_requested_rate;
      pre_r  <= PRESCALE_MIN;
      acc_r  <= {6'd0, in_requested_rate, 10'd0};
    end
    if (cmd.pre_step) begin
      pre_r <= pre_r + 8'd2;
      acc_r <= acc_r + {7'd0, rate_r, 9'd0};
    end
    if (cmd.mul) begin
      pr_r <= pr_mul;
    end
    if (cmd.post_init) begin
      prod_r <= {pr_r, 8'd0} - {8'd0, pr_r};
      d_r    <= {pre_r, 8'd0} - {8'd0, pre_r};
      post_r <= POSTDIV_MAX;
    end
    if (cmd.post_step) begin
      prod_r <= prod_r - {8'd0, pr_r};
      d_r    <= d_r - {8'd0, pre_r};
      post_r <= post_r - 9'd1;
    end
    if (cmd.div_init) begin
      den_r <= d_r + {8'd0, pre_r};
      rem_r <= '0;
      quo_r <= clk_hz_r;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= fits ? 16'(trial - {1'b0, den_r}) : trial[15:0];
      quo_r <= {quo_r[30:0], fits};
      cnt_r <= cnt_r + 5'd1;
    end
    if (cmd.out_load) begin
      if (cmd.out_err) begin
        out_prescale_value <= '0;
        out_rate_field     <= '0;
        out_achieved_rate  <= '0;
        out_too_low        <= 1'b1;
      end else begin
        out_prescale_value <= pre_r;
        out_rate_field     <= rate_field;
        out_achieved_rate  <= quo_r[30:0];
        out_too_low        <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/spi_clock_divider_search.sv -----
// Serial clock divider search, top level.
// Joins the controller and the datapath; depends on spicd_pkg, spicd_ctrl, spicd_dp.
//
// Usage:
//   Input channel (in_valid/in_ready, in_requested_rate): one transaction per
//   request. in_ready is high only while the search engine is idle.
//   Result channel (out_valid/out_ready): prescaler, rate field, achieved rate
//   and the too_low flag, held in an output register until taken.
//   Config channel (cfg_valid/cfg_ready, cfg_input_clock_hz): always ready;
//   write it only while no request is in flight.
// Sequence: the prescaler search tries the even prescalers in turn (up to
//   127), the post-divider search tries dividers downwards from 256 (up to
//   255 of them), then the 32-bit restoring divider runs, with set-up and
//   hand-over in the states ST_MUL, ST_POST_INIT, ST_DIV_INIT and ST_DONE.
//   A too-low request tries every prescaler.
//   One request is processed at a time; the next is accepted as soon as the
//   previous result has entered the output register.
// Reset: input clock register returns to 125 MHz, no result pending.
// Receiver stall: the finished result waits in the output register; a new
//   request may be accepted and searched meanwhile, and its result waits
//   in the engine until the output register is free.
`default_nettype none

module spi_clock_divider_search (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [31:0] cfg_input_clock_hz,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [31:0] in_requested_rate,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [7:0]  out_prescale_value,
  output logic [7:0]  out_rate_field,
  output logic [30:0] out_achieved_rate,
  output logic        out_too_low
);
  import spicd_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  spicd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  spicd_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_input_clock_hz (cfg_input_clock_hz),
    .in_requested_rate  (in_requested_rate),
    .cmd                (cmd),
    .sts                (sts),
    .out_prescale_value (out_prescale_value),
    .out_rate_field     (out_rate_field),
    .out_achieved_rate  (out_achieved_rate),
    .out_too_low        (out_too_low)
  );

endmodule

`default_nettype wire

// ----- verif/spi_clock_divider_search_tb.sv -----
// Self-checking testbench for spi_clock_divider_search: directed table, then random requests
// over several clock settings; checked against fixed values or a local divider predictor.
// Depends on spicd_pkg and the spi_clock_divider_search RTL.
`timescale 1ns / 100ps

module spi_clock_divider_search_tb;
  import spicd_pkg::*;

  typedef struct packed {
    logic [7:0]  prescale_value;
    logic [7:0]  rate_field;
    logic [30:0] achieved_rate;
    logic        too_low;
  } divider_t;

  typedef struct packed {
    logic [31:0] clock_hz;
    logic [31:0] rate;
    logic        fixed;
    divider_t    want;
  } stim_row_t;

  localparam divider_t NO_FIT   = '{8'd0, 8'd0, 31'd0, 1'b1};
  localparam divider_t BY_MODEL = '0;
  localparam divider_t SLOWEST  = '{8'd2, 8'd0, 31'd0, 1'b0};
  localparam int       N_ROWS   = 21;
  localparam int       N_RANDOM = 80;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_input_clock_hz;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_requested_rate;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_prescale_value;
  logic [7:0]  out_rate_field;
  logic [30:0] out_achieved_rate;
  logic        out_too_low;

  spi_clock_divider_search dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_input_clock_hz (cfg_input_clock_hz),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_requested_rate  (in_requested_rate),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_prescale_value (out_prescale_value),
    .out_rate_field     (out_rate_field),
    .out_achieved_rate  (out_achieved_rate),
    .out_too_low        (out_too_low)
  );

  // clock, rate, fixed expectation?, expectation
  stim_row_t directed_rows [N_ROWS] = '{
    '{CLK_RESET_HZ, 32'd0,          1'b1, NO_FIT},
    '{CLK_RESET_HZ, 32'd1,          1'b1, NO_FIT},
    '{CLK_RESET_HZ, 32'd1907,       1'b0, BY_MODEL},
    '{CLK_RESET_HZ, 32'd1908,       1'b0, BY_MODEL},
    '{CLK_RESET_HZ, 32'd200000,     1'b0, BY_MODEL},
    '{CLK_RESET_HZ, 32'd1000000,    1'b0, BY_MODEL},
    '{CLK_RESET_HZ, 32'd10000000,   1'b0, BY_MODEL},
    '{CLK_RESET_HZ, 32'd62500000,   1'b0, BY_MODEL},
    '{CLK_RESET_HZ, 32'd125000000,  1'b0, BY_MODEL},
    '{CLK_RESET_HZ, 32'hFFFFFFFF,   1'b1, '{8'd2, 8'd0, 31'd62500000, 1'b0}},
    '{32'hFFFFFFFF, 32'd0,          1'b1, NO_FIT},
    '{32'hFFFFFFFF, 32'd1,          1'b1, NO_FIT},
    '{32'hFFFFFFFF, 32'd65535,      1'b0, BY_MODEL},
    '{32'hFFFFFFFF, 32'd65536,      1'b0, BY_MODEL},
    '{32'hFFFFFFFF, 32'hFFFFFFFF,   1'b1, '{8'd2, 8'd0, 31'h7FFFFFFF, 1'b0}},
    '{32'd1,        32'd0,          1'b1, NO_FIT},
    '{32'd1,        32'd1,          1'b1, SLOWEST},
    '{32'd1,        32'hFFFFFFFF,   1'b1, SLOWEST},
    '{32'd0,        32'd0,          1'b1, NO_FIT},
    '{32'd0,        32'd1,          1'b1, SLOWEST},
    '{32'd0,        32'hFFFFFFFF,   1'b1, SLOWEST}
  };

  divider_t    pending_divs [$];
  logic [31:0] clock_hz;
  int          errors;
  int          checked;
  int          flagged;
  int          clock_writes;
  int          run_left  [2];
  bit          run_quiet [2];

  function automatic divider_t predict_divider(logic [31:0] clk_hz, logic [31:0] rate);
    logic [63:0] c;
    logic [63:0] r;
    logic [63:0] pre;
    logic [63:0] post;
    logic [63:0] quot;
    divider_t    d;
    c = {32'd0, clk_hz};
    r = {32'd0, rate};
    d = '0;
    pre = 2;
    while (pre <= 254 && !(c < (pre + 2) * 256 * r))
      pre += 2;
    if (pre > 254) begin
      d.too_low = 1'b1;
      return d;
    end
    post = 256;
    while (post > 1 && !(c / (pre * (post - 1)) > r))
      post -= 1;
    quot = c / (pre * post);
    d.prescale_value = pre[7:0];
    d.rate_field     = post[7:0] - 8'd1;
    d.achieved_rate  = quot[30:0];
    return d;
  endfunction

  // Wait length per transaction, with occasional stretches of back-to-back traffic.
  function automatic int draw_wait(int side);
    if (run_left[side] == 0) begin
      run_quiet[side] = ($urandom_range(0, 2) == 0);
      run_left[side]  = $urandom_range(5, 20);
    end
    run_left[side]--;
    return run_quiet[side] ? 0 : $urandom_range(0, 14);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Called at a clock edge; returns at the edge where the request was taken.
  task automatic send_request(logic [31:0] rate, bit fixed, divider_t want);
    int gap;
    gap = draw_wait(0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_requested_rate <= rate;
    do @(posedge clk); while (!in_ready);
    pending_divs.push_back(fixed ? want : predict_divider(clock_hz, rate));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_divs.size() != 0) @(posedge clk);
  endtask

  task automatic set_input_clock(logic [31:0] value);
    wait_for_results();
    cfg_valid          <= 1'b1;
    cfg_input_clock_hz <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    clock_hz = value;
    clock_writes++;
  endtask

  // Result side: random stalls, every transaction checked against the oldest expectation.
  initial begin
    divider_t want;
    int       stall;
    forever begin
      stall = draw_wait(1);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && rst_n));
      if (pending_divs.size() == 0) begin
        $error("result transaction with nothing outstanding");
        errors++;
      end else begin
        want = pending_divs.pop_front();
        checked++;
        if (out_too_low) flagged++;
        if (out_prescale_value !== want.prescale_value) begin
          $error("prescale_value: expected %0d, got %0d", want.prescale_value,
                 out_prescale_value);
          errors++;
        end
        if (out_rate_field !== want.rate_field) begin
          $error("rate_field: expected %0d, got %0d", want.rate_field, out_rate_field);
          errors++;
        end
        if (out_achieved_rate !== want.achieved_rate) begin
          $error("achieved_rate: expected %0d, got %0d", want.achieved_rate,
                 out_achieved_rate);
          errors++;
        end
        if (out_too_low !== want.too_low) begin
          $error("too_low: expected %0d, got %0d", want.too_low, out_too_low);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [31:0] phase_clocks [6];
    logic [31:0] rate;
    int          per_phase;
    rst_n              <= 1'b0;
    cfg_valid          <= 1'b0;
    cfg_input_clock_hz <= '0;
    in_valid           <= 1'b0;
    in_requested_rate  <= '0;
    clock_hz     = CLK_RESET_HZ;
    errors       = 0;
    checked      = 0;
    flagged      = 0;
    clock_writes = 0;
    run_left     = '{0, 0};
    run_quiet    = '{0, 0};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      if (directed_rows[i].clock_hz != clock_hz)
        set_input_clock(directed_rows[i].clock_hz);
      send_request(directed_rows[i].rate, directed_rows[i].fixed, directed_rows[i].want);
    end

    phase_clocks = '{CLK_RESET_HZ, 32'd48000000, 32'd1, 32'hFFFFFFFF, $urandom,
                     $urandom_range(1, 100000)};
    per_phase = N_RANDOM / 6 + 1;
    for (int p = 0; p < 6; p++) begin
      set_input_clock(phase_clocks[p]);
      for (int k = 0; k < per_phase; k++) begin
        // hold off mid-phase until the block has drained
        if (p == 2 && k == per_phase / 2)
          wait_for_results();
        case ($urandom_range(0, 4))
          0: rate = $urandom;
          1: rate = $urandom >> $urandom_range(0, 31);
          2: rate = clock_hz / $urandom_range(1, 70000) + $urandom_range(0, 1);
          3: rate = (clock_hz >> 16) + $urandom_range(0, 2);
          default: rate = $urandom_range(0, 3);
        endcase
        send_request(rate, 1'b0, BY_MODEL);
      end
    end

    in_valid <= 1'b0;
    while (pending_divs.size() != 0) @(posedge clk);
    repeat (450) @(posedge clk);
    $display("Checked %0d divider results over %0d input clock writes, %0d of them too low.",
             checked, clock_writes, flagged);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
